// ----- rtl/graph_depth_first_search_unit_assert.svh -----
// assertion macros for the depth-first search unit
`ifndef GRAPH_DEPTH_FIRST_SEARCH_UNIT_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GDFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GDFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GDFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GDFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/gdfs_pkg.sv -----
package gdfs_pkg;
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES = 256;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int LW = EW + 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam logic OP_ADD = 1'b0;

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GREY = 2'd2;
    localparam logic [1:0] COLOR_BLACK = 2'd3;

    typedef struct packed {
        logic [VW-1:0] dest;
        logic [LW-1:0] next;
    } edge_t;

    // one write and one read port of the edge store
    typedef struct packed {
        logic          we;
        logic [EW-1:0] waddr;
        edge_t         wdata;
        logic          re;
        logic [EW-1:0] raddr;
    } estore_req_t;
endpackage

// ----- rtl/gdfs_edge_store.sv -----
module gdfs_edge_store
    import gdfs_pkg::*;
(
    input  logic        clk,
    input  estore_req_t req,
    output edge_t       rdata
);
    edge_t mem [MAX_EDGES];
    edge_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/graph_depth_first_search_unit.sv -----
// graph depth-first search unit
// in channel: in_valid/in_stall with op, source, destination. op 0 adds the edge
// source->destination at the head of the source's list, op 1 runs a full search.
// out channel: out_valid/out_stall with kind, status, vertex, edge_total, last.
// an add gives one word (status), loaded in S_ADD once the output register is free;
// the next item is taken once that word sits in the output register, unless stalled.
// a search gives one word per active vertex, in finishing order, last on the
// final one; each edge step reads the edge store once, issuing the read in S_TOP
// and using the data in S_READ; the 32 colors are all cleared together when the
// item is accepted.
// a stalled receiver holds the output word; the search runs on to its next finish and waits there.
// vertex_count is written by cfg_we/cfg_data; the user writes it only while idle, as
// the block does not enforce it; values above 32 act as 32 and 0 makes every add fail
// and every search empty. reset (rst_n low, async) empties all lists, zeroes the
// edge count and sets vertex_count to 32; edge store contents need no clear since
// only linked entries are read.
`include "graph_depth_first_search_unit_assert.svh"
module graph_depth_first_search_unit
    import gdfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [5:0]    cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          op,
    input  logic [4:0]    source,
    input  logic [4:0]    destination,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          kind,
    output logic [1:0]    status,
    output logic [4:0]    vertex,
    output logic [8:0]    edge_total,
    output logic          last
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROOT  = 6'b000010,
        S_TOP   = 6'b000100,
        S_READ  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ADD   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] vcount_reg;
    logic [LW-1:0] head_reg [MAX_VERTICES];
    logic [1:0] color_reg [MAX_VERTICES];
    logic [VW-1:0] stk_vtx_reg [MAX_VERTICES];
    logic [LW-1:0] stk_cur_reg [MAX_VERTICES];
    logic [VW:0] depth_reg;
    logic [VW:0] root_reg;
    logic [8:0] used_reg;
    logic [VW:0] done_reg;
    logic [VW-1:0] src_reg, dst_reg;
    logic add_ok_reg;
    logic [1:0] add_st_reg;
    logic ov_reg, okind_reg, olast_reg;
    logic ov_next;
    logic [1:0] ost_reg;
    logic [VW-1:0] ovtx_reg;

    estore_req_t req;
    edge_t rdata;
    logic [VW:0] n_act;
    logic [VW-1:0] top_idx;
    logic out_free;

    gdfs_edge_store u_store (.clk(clk), .req(req), .rdata(rdata));

    assign n_act = (vcount_reg > 6'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                                   : (VW+1)'(vcount_reg);
    assign top_idx = VW'(depth_reg - 1'b1);
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    // output word loads on an add or a finish, otherwise holds while stalled
    assign ov_next = (((state_reg == S_ADD) || (state_reg == S_EMIT)) && out_free)
                     || (ov_reg && out_stall);

    always_comb
    begin
        req = '0;
        req.waddr = EW'(used_reg);
        req.wdata.dest = dst_reg;
        req.wdata.next = head_reg[src_reg];
        req.we = (state_reg == S_ADD) && add_ok_reg;
        req.raddr = EW'(stk_cur_reg[top_idx]);
        req.re = (state_reg == S_TOP) && (stk_cur_reg[top_idx] < NULL_LINK);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = (op == OP_ADD) ? S_ADD : S_ROOT;
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (root_reg >= n_act)
                begin
                    state_next = S_IDLE;
                end
                else if (color_reg[VW'(root_reg)] == COLOR_WHITE)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                if (stk_cur_reg[top_idx] >= NULL_LINK)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_TOP;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (depth_reg == (VW+1)'(1)) ? S_ROOT : S_TOP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= 6'(MAX_VERTICES);
            used_reg <= '0;
            ov_reg <= 1'b0;
            depth_reg <= '0;
            root_reg <= '0;
            done_reg <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                head_reg[i] <= NULL_LINK;
                color_reg[i] <= COLOR_WHITE;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        src_reg <= source;
                        dst_reg <= destination;
                        add_ok_reg <= 1'b0;
                        if ((VW+1)'(source) >= n_act || (VW+1)'(destination) >= n_act)
                        begin
                            add_st_reg <= ST_BAD_VERTEX;
                        end
                        else if (used_reg >= 9'(MAX_EDGES))
                        begin
                            add_st_reg <= ST_FULL;
                        end
                        else
                        begin
                            add_st_reg <= ST_OK;
                            add_ok_reg <= 1'b1;
                        end
                        root_reg <= '0;
                        depth_reg <= '0;
                        done_reg <= '0;
                        for (int i = 0; i < MAX_VERTICES; i++)
                        begin
                            color_reg[i] <= COLOR_WHITE;
                        end
                    end
                end
                S_ADD:
                begin
                    if (out_free)
                    begin
                        if (add_ok_reg)
                        begin
                            head_reg[src_reg] <= LW'(used_reg);
                            used_reg <= used_reg + 9'd1;
                        end
                        okind_reg <= KIND_INSERT;
                        ost_reg <= add_st_reg;
                        ovtx_reg <= '0;
                        olast_reg <= 1'b1;
                    end
                end
                S_ROOT:
                begin
                    if (root_reg < n_act)
                    begin
                        if (color_reg[VW'(root_reg)] == COLOR_WHITE)
                        begin
                            color_reg[VW'(root_reg)] <= COLOR_GREY;
                            stk_vtx_reg[0] <= VW'(root_reg);
                            stk_cur_reg[0] <= head_reg[VW'(root_reg)];
                            depth_reg <= (VW+1)'(1);
                        end
                        root_reg <= root_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    // cursor advance and possible push of a white neighbor
                    stk_cur_reg[top_idx] <= rdata.next;
                    if ((VW+1)'(rdata.dest) < n_act && color_reg[rdata.dest] == COLOR_WHITE
                        && depth_reg < (VW+1)'(MAX_VERTICES))
                    begin
                        color_reg[rdata.dest] <= COLOR_GREY;
                        stk_vtx_reg[VW'(depth_reg)] <= rdata.dest;
                        stk_cur_reg[VW'(depth_reg)] <= head_reg[rdata.dest];
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        color_reg[stk_vtx_reg[top_idx]] <= COLOR_BLACK;
                        depth_reg <= depth_reg - 1'b1;
                        done_reg <= done_reg + 1'b1;
                        okind_reg <= KIND_FINISH;
                        ost_reg <= ST_OK;
                        ovtx_reg <= stk_vtx_reg[top_idx];
                        olast_reg <= (done_reg + 1'b1 == n_act);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign kind = okind_reg;
    assign status = ost_reg;
    assign vertex = ovtx_reg;
    assign edge_total = used_reg;
    assign last = olast_reg;

    `GDFS_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall,
        "input taken while busy")
    `GDFS_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1,
        depth_reg <= (VW+1)'(MAX_VERTICES), "stack overflow")
    `GDFS_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1,
        used_reg <= 9'(MAX_EDGES), "edge count overflow")
    `GDFS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(vertex) && $stable(last), "stalled word changed")
endmodule

// ----- tb/sv/tb_graph_depth_first_search_unit.sv -----
module tb_graph_depth_first_search_unit;
    import gdfs_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [4:0] vertex;
        logic [8:0] edge_total;
        logic       last;
    } word_t;

    typedef struct {
        logic       op;
        logic [4:0] src;
        logic [4:0] dst;
        logic       typed;
        word_t      want;
    } stim_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [4:0] source;
    logic [4:0] destination;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [1:0] status;
    logic [4:0] vertex;
    logic [8:0] edge_total;
    logic       last;

    graph_depth_first_search_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .source(source),
        .destination(destination), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .status(status), .vertex(vertex), .edge_total(edge_total),
        .last(last)
    );

    // graph shadow
    int unsigned n_cfg;
    int unsigned head_of[MAX_VERTICES];
    int unsigned edge_dst[MAX_EDGES];
    int unsigned edge_nxt[MAX_EDGES];
    int unsigned n_edges;
    word_t       pending_words[$];
    int          errors;
    bit          rx_hold;
    bit          no_idle;
    int          hold_cycles;
    int          sent;
    int          k;
    stim_t       directed[$];
    stim_t       s;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report(input string what, input word_t got, input word_t want);
        errors++;
        $display("mismatch %s: got k%0d s%0d v%0d e%0d l%0d, want k%0d s%0d v%0d e%0d l%0d",
            what, got.kind, got.status, got.vertex, got.edge_total, got.last,
            want.kind, want.status, want.vertex, want.edge_total, want.last);
    endtask

    function automatic word_t insert_word(input logic [1:0] st);
        word_t w;
        w = '{KIND_INSERT, st, 5'd0, n_edges[8:0], 1'b1};
        return w;
    endfunction

    function automatic void reset_graph();
        n_cfg = 32;
        n_edges = 0;
        for (int i = 0; i < MAX_VERTICES; i++)
            head_of[i] = MAX_EDGES;
    endfunction

    function automatic void predict_words(input logic o, input logic [4:0] a,
                                          input logic [4:0] b);
        int unsigned n;
        int unsigned color[MAX_VERTICES];
        int unsigned st_v[MAX_VERTICES];
        int unsigned st_c[MAX_VERTICES];
        int          sp;
        int          first;
        int unsigned e;
        int unsigned w;
        word_t       wd;
        n = (n_cfg > MAX_VERTICES) ? MAX_VERTICES : n_cfg;
        if (o == OP_ADD)
        begin
            if (a >= n || b >= n)
                pending_words.push_back(insert_word(ST_BAD_VERTEX));
            else if (n_edges >= MAX_EDGES)
                pending_words.push_back(insert_word(ST_FULL));
            else
            begin
                edge_dst[n_edges] = b;
                edge_nxt[n_edges] = head_of[a];
                head_of[a] = n_edges;
                n_edges++;
                pending_words.push_back(insert_word(ST_OK));
            end
            return;
        end
        first = pending_words.size();
        for (int i = 0; i < MAX_VERTICES; i++)
            color[i] = COLOR_WHITE;
        for (int r = 0; r < n; r++)
        begin
            if (color[r] != COLOR_WHITE)
                continue;
            color[r] = COLOR_GREY;
            st_v[0] = r;
            st_c[0] = head_of[r];
            sp = 1;
            while (sp > 0)
            begin
                e = st_c[sp-1];
                if (e >= MAX_EDGES)
                begin
                    color[st_v[sp-1]] = COLOR_BLACK;
                    wd = '{KIND_FINISH, ST_OK, st_v[sp-1][4:0], n_edges[8:0], 1'b0};
                    pending_words.push_back(wd);
                    sp--;
                end
                else
                begin
                    w = edge_dst[e];
                    st_c[sp-1] = edge_nxt[e];
                    if (w < n && color[w] == COLOR_WHITE)
                    begin
                        color[w] = COLOR_GREY;
                        st_v[sp] = w;
                        st_c[sp] = head_of[w];
                        sp++;
                    end
                end
            end
        end
        if (pending_words.size() > first)
            pending_words[pending_words.size()-1].last = 1'b1;
    endfunction

    // output side: random stall, plus a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= rx_hold || (!no_idle && $urandom_range(99) < 26);
    end

    initial begin
        rx_hold = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        rx_hold = 1'b1;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++)
            @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, status, vertex, edge_total, last};
            if (pending_words.size() == 0)
                report("unexpected word", got, got);
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report("field", got, want);
            end
        end
    end

    // valid stays up after acceptance until the next item or an idle cycle replaces it
    task automatic send_item(input logic o, input logic [4:0] a, input logic [4:0] b);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        source <= a;
        destination <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_words(o, a, b);
    endtask

    task automatic drain_and_config(input logic [5:0] value);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_words.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (120) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_cfg = value;
    endtask

    function automatic stim_t row(input logic o, input logic [4:0] a, input logic [4:0] b,
                                  input logic t, input word_t w);
        stim_t r;
        r = '{o, a, b, t, w};
        return r;
    endfunction

    initial begin
        errors = 0;
        no_idle = 1'b0;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 6'd0;
        in_valid = 1'b0;
        op = 1'b0;
        source = 5'd0;
        destination = 5'd0;
        reset_graph();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; typed results checked against the predicted word too
        directed.push_back(row(1'b1, 5'd0, 5'd0, 1'b0, '0));
        directed.push_back(row(1'b0, 5'd0, 5'd31, 1'b1, '{KIND_INSERT, ST_OK, 5'd0, 9'd1, 1'b1}));
        directed.push_back(row(1'b0, 5'd31, 5'd0, 1'b1, '{KIND_INSERT, ST_OK, 5'd0, 9'd2, 1'b1}));
        directed.push_back(row(1'b0, 5'd5, 5'd5, 1'b1, '{KIND_INSERT, ST_OK, 5'd0, 9'd3, 1'b1}));
        directed.push_back(row(1'b0, 5'd0, 5'd31, 1'b1, '{KIND_INSERT, ST_OK, 5'd0, 9'd4, 1'b1}));
        directed.push_back(row(1'b0, 5'd0, 5'd1, 1'b0, '0));
        directed.push_back(row(1'b0, 5'd1, 5'd2, 1'b0, '0));
        directed.push_back(row(1'b0, 5'd2, 5'd0, 1'b0, '0));
        directed.push_back(row(1'b1, 5'd31, 5'd31, 1'b0, '0));
        foreach (directed[i])
        begin
            s = directed[i];
            send_item(s.op, s.src, s.dst);
            if (s.typed && pending_words[pending_words.size()-1] !== s.want)
                report("typed row", pending_words[pending_words.size()-1], s.want);
        end

        // shrunk graph: bad vertex on the edge, search skips high edges
        drain_and_config(6'd4);
        send_item(1'b0, 5'd4, 5'd0);
        send_item(1'b0, 5'd0, 5'd4);
        send_item(1'b0, 5'd3, 5'd2);
        send_item(1'b1, 5'd0, 5'd0);
        drain_and_config(6'd0);
        send_item(1'b0, 5'd0, 5'd0);
        send_item(1'b1, 5'd0, 5'd0);
        drain_and_config(6'd63);
        send_item(1'b1, 5'd0, 5'd0);
        drain_and_config(6'd1);
        send_item(1'b0, 5'd0, 5'd0);
        send_item(1'b1, 5'd0, 5'd0);

        // random phases: mostly small graphs, edges biased into range
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: drain_and_config(6'd8);
                1: drain_and_config(6'd32);
                2: drain_and_config(6'd2);
                3: drain_and_config(6'd16);
                4: drain_and_config(6'(33 + $urandom_range(30)));
                default: drain_and_config(6'(1 + $urandom_range(31)));
            endcase
            no_idle = (ph == 3);
            for (int j = 0; j < 50; j++)
            begin
                k = (n_cfg > 32) ? 32 : n_cfg;
                if ($urandom_range(9) == 0)
                    send_item(1'b1, 5'($urandom), 5'($urandom));
                else if ($urandom_range(9) == 0)
                    send_item(1'b0, 5'($urandom), 5'($urandom));
                else
                    send_item(1'b0, 5'($urandom_range(k - 1)), 5'($urandom_range(k - 1)));
                sent++;
            end
            send_item(1'b1, 5'd0, 5'd0);
        end
        no_idle = 1'b0;
        // fill the store past capacity
        drain_and_config(6'd32);
        while (n_edges < MAX_EDGES)
            send_item(1'b0, 5'($urandom_range(15)), 5'($urandom_range(15)));
        send_item(1'b0, 5'd3, 5'd7);
        send_item(1'b0, 5'd31, 5'd31);
        send_item(1'b1, 5'd0, 5'd0);
        in_valid <= 1'b0;

        k = 0;
        while (pending_words.size() != 0 && k < 500000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (120) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
